FILE: rtl/pcx_pkg.sv
// Package for the PCX 8-bit RLE decoder: header offsets, result codes,
// output selects and the command/status structs between controller and datapath.
// No dependencies.
package pcx_pkg;

  localparam int unsigned HdrIdxW = 7;

  localparam logic [7:0] RleMark = 8'd192;

  localparam logic [HdrIdxW-1:0] IDX_ENCODING = 7'd2;
  localparam logic [HdrIdxW-1:0] IDX_BPP      = 7'd3;
  localparam logic [HdrIdxW-1:0] IDX_W_LO     = 7'd8;
  localparam logic [HdrIdxW-1:0] IDX_W_HI     = 7'd9;
  localparam logic [HdrIdxW-1:0] IDX_H_LO     = 7'd10;
  localparam logic [HdrIdxW-1:0] IDX_H_HI     = 7'd11;
  localparam logic [HdrIdxW-1:0] IDX_PLANES   = 7'd65;
  localparam logic [HdrIdxW-1:0] IDX_LAST     = 7'd127;
  localparam logic [HdrIdxW-1:0] IDX_AFTER_SOF = 7'd1;

  localparam logic [7:0] ENC_RLE  = 8'd1;
  localparam logic [7:0] BPP_8    = 8'd8;
  localparam logic [7:0] PLANES_1 = 8'd1;

  localparam logic [1:0] STS_PIXEL   = 2'd0;
  localparam logic [1:0] STS_BAD_FMT = 2'd1;
  localparam logic [1:0] STS_CORRUPT = 2'd2;

  localparam logic [1:0] SEL_BYTE    = 2'd0;
  localparam logic [1:0] SEL_RUN     = 2'd1;
  localparam logic [1:0] SEL_FMT     = 2'd2;
  localparam logic [1:0] SEL_CORRUPT = 2'd3;

  typedef struct packed {
    logic       clear;
    logic       hdr_step;
    logic       load_left;
    logic       set_run;
    logic       take_run;
    logic       dec_run;
    logic       load_out;
    logic [1:0] out_sel;
    logic       run_last;
  } pcx_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hdr_check;
    logic hdr_last;
    logic fmt_bad;
    logic is_mark;
    logic run_pending;
    logic run_zero;
    logic run_one;
    logic left_one;
    logic left_zero;
  } pcx_sts_t;

endpackage

FILE: rtl/pcx_if.sv
// Valid/ready channel interfaces for the PCX decoder: file bytes in, results out.
// Depends on nothing.
interface pcx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface pcx_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_value;
  logic [1:0]  status;
  logic        run_last;
  logic        image_last;
  logic [16:0] image_width;
  logic [16:0] image_height;

  modport source (output valid, output pixel_value, output status, output run_last,
                  output image_last, output image_width, output image_height, input ready);
  modport sink   (input valid, input pixel_value, input status, input run_last,
                  input image_last, input image_width, input image_height, output ready);
endinterface

FILE: rtl/pcx_rle_decoder.sv
// Top level of the PCX 8-bit, one-plane RLE decoder.
// Depends on pcx_pkg, pcx_if, pcx_ctrl and pcx_dpath.
//
//   Channel | Dir | Carries                                   | Transaction
//   byte_i  | in  | file_byte, start_of_file                  | valid & ready
//   pix_o   | out | pixel_value, status, run_last, image_last,| valid & ready
//           |     | image_width, image_height                 |
//
// A literal is loaded into the single output register as it is accepted; the byte
// after a run mark of count c gives c pixels (none for c = 0), one pixel per cycle
// while the output is taken, plus an overflow status if the run overruns the image.
// Input is held off while a run is emitted and while the output register is full
// and not being taken. Reset is asynchronous; after it, bytes are dropped until a
// start-of-file mark. One multiply of the image size happens on the last header byte.
module pcx_rle_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcx_byte_if.sink   byte_i,
  pcx_pix_if.source  pix_o
);

  pcx_pkg::pcx_cmd_t cmd;
  pcx_pkg::pcx_sts_t sts;

  pcx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_sof_i   (byte_i.start_of_file),
    .sts_i      (sts),
    .in_ready_o (byte_i.ready),
    .cmd_o      (cmd)
  );

  pcx_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .file_byte_i    (byte_i.file_byte),
    .cmd_i          (cmd),
    .out_ready_i    (pix_o.ready),
    .sts_o          (sts),
    .out_valid_o    (pix_o.valid),
    .pixel_value_o  (pix_o.pixel_value),
    .status_o       (pix_o.status),
    .run_last_o     (pix_o.run_last),
    .image_last_o   (pix_o.image_last),
    .image_width_o  (pix_o.image_width),
    .image_height_o (pix_o.image_height)
  );

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_corrupt_after_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && cmd.out_sel == pcx_pkg::SEL_CORRUPT) |-> sts.left_zero)
    else $error("overflow status before the image is full");

  a_pixel_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && (cmd.out_sel == pcx_pkg::SEL_BYTE || cmd.out_sel == pcx_pkg::SEL_RUN))
      |-> !sts.left_zero)
    else $error("pixel emitted past the end of the image");

  a_no_input_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && cmd.out_sel == pcx_pkg::SEL_RUN) |-> !byte_i.ready)
    else $error("byte accepted while a run is being emitted");

endmodule

FILE: rtl/pcx_dpath.sv
// Datapath of the PCX decoder: header fields, pixel and run counters, output register.
// Depends on pcx_pkg; driven by pcx_ctrl through pcx_cmd_t.
module pcx_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         file_byte_i,
  input  pcx_pkg::pcx_cmd_t  cmd_i,
  input  logic               out_ready_i,
  output pcx_pkg::pcx_sts_t  sts_o,
  output logic               out_valid_o,
  output logic [7:0]         pixel_value_o,
  output logic [1:0]         status_o,
  output logic               run_last_o,
  output logic               image_last_o,
  output logic [16:0]        image_width_o,
  output logic [16:0]        image_height_o
);

  logic [pcx_pkg::HdrIdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        fmt_ok_q, fmt_ok_d;
  logic [32:0] left_q, left_d;
  logic [5:0]  run_cnt_q, run_cnt_d;
  logic        run_pend_q, run_pend_d;
  logic [7:0]  run_byte_q, run_byte_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  pix_q, pix_d;
  logic [1:0]  status_q, status_d;
  logic        run_last_q, run_last_d;
  logic        img_last_q, img_last_d;
  logic [16:0] out_w_q, out_w_d;
  logic [16:0] out_h_q, out_h_d;

  logic [16:0] width_p1;
  logic [16:0] height_p1;
  logic [33:0] area;
  logic [7:0]  run_raw;
  logic        pix_emit;

  assign width_p1  = {1'b0, width_q} + 17'd1;
  assign height_p1 = {1'b0, height_q} + 17'd1;
  assign area      = 34'(width_p1) * 34'(height_p1);
  assign run_raw   = file_byte_i - pcx_pkg::RleMark;
  assign pix_emit  = cmd_i.load_out &&
                     (cmd_i.out_sel == pcx_pkg::SEL_BYTE || cmd_i.out_sel == pcx_pkg::SEL_RUN);

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.hdr_check   = (hdr_idx_q == pcx_pkg::IDX_PLANES);
  assign sts_o.hdr_last    = (hdr_idx_q == pcx_pkg::IDX_LAST);
  assign sts_o.fmt_bad     = !fmt_ok_q || (file_byte_i != pcx_pkg::PLANES_1);
  assign sts_o.is_mark     = (file_byte_i >= pcx_pkg::RleMark);
  assign sts_o.run_pending = run_pend_q;
  assign sts_o.run_zero    = (run_cnt_q == 6'd0);
  assign sts_o.run_one     = (run_cnt_q == 6'd1);
  assign sts_o.left_one    = (left_q == 33'd1);
  assign sts_o.left_zero   = (left_q == 33'd0);

  always_comb begin
    hdr_idx_d  = hdr_idx_q;
    width_d    = width_q;
    height_d   = height_q;
    fmt_ok_d   = fmt_ok_q;
    left_d     = left_q;
    run_cnt_d  = run_cnt_q;
    run_pend_d = run_pend_q;
    run_byte_d = run_byte_q;

    if (cmd_i.clear) begin
      hdr_idx_d  = pcx_pkg::IDX_AFTER_SOF;
      width_d    = 16'd0;
      height_d   = 16'd0;
      fmt_ok_d   = 1'b1;
      left_d     = 33'd0;
      run_cnt_d  = 6'd0;
      run_pend_d = 1'b0;
    end else begin
      if (cmd_i.hdr_step) begin
        hdr_idx_d = hdr_idx_q + 7'd1;
        case (hdr_idx_q)
          pcx_pkg::IDX_ENCODING: begin
            if (file_byte_i != pcx_pkg::ENC_RLE) fmt_ok_d = 1'b0;
          end
          pcx_pkg::IDX_BPP: begin
            if (file_byte_i != pcx_pkg::BPP_8) fmt_ok_d = 1'b0;
          end
          pcx_pkg::IDX_W_LO: width_d  = {width_q[15:8], file_byte_i};
          pcx_pkg::IDX_W_HI: width_d  = {file_byte_i, width_q[7:0]};
          pcx_pkg::IDX_H_LO: height_d = {height_q[15:8], file_byte_i};
          pcx_pkg::IDX_H_HI: height_d = {file_byte_i, height_q[7:0]};
          default: ;
        endcase
      end
      if (cmd_i.load_left) begin
        left_d     = area[32:0];
        run_cnt_d  = 6'd0;
        run_pend_d = 1'b0;
      end
      if (cmd_i.set_run) begin
        run_cnt_d  = run_raw[5:0];
        run_pend_d = 1'b1;
      end
      if (cmd_i.take_run) begin
        run_pend_d = 1'b0;
        run_byte_d = file_byte_i;
      end
      if (cmd_i.dec_run) run_cnt_d = run_cnt_q - 6'd1;
      if (pix_emit) left_d = left_q - 33'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pix_d       = pix_q;
    status_d    = status_q;
    run_last_d  = run_last_q;
    img_last_d  = img_last_q;
    out_w_d     = out_w_q;
    out_h_d     = out_h_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      run_last_d  = cmd_i.run_last;
      img_last_d  = pix_emit && (left_q == 33'd1);
      out_w_d     = width_p1;
      out_h_d     = height_p1;
      case (cmd_i.out_sel)
        pcx_pkg::SEL_BYTE: begin
          pix_d    = file_byte_i;
          status_d = pcx_pkg::STS_PIXEL;
        end
        pcx_pkg::SEL_RUN: begin
          pix_d    = run_byte_q;
          status_d = pcx_pkg::STS_PIXEL;
        end
        pcx_pkg::SEL_FMT: begin
          pix_d    = 8'd0;
          status_d = pcx_pkg::STS_BAD_FMT;
        end
        default: begin
          pix_d    = 8'd0;
          status_d = pcx_pkg::STS_CORRUPT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q   <= '0;
      width_q     <= 16'd0;
      height_q    <= 16'd0;
      fmt_ok_q    <= 1'b1;
      left_q      <= 33'd0;
      run_cnt_q   <= 6'd0;
      run_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_idx_q   <= hdr_idx_d;
      width_q     <= width_d;
      height_q    <= height_d;
      fmt_ok_q    <= fmt_ok_d;
      left_q      <= left_d;
      run_cnt_q   <= run_cnt_d;
      run_pend_q  <= run_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_byte_q <= run_byte_d;
    pix_q      <= pix_d;
    status_q   <= status_d;
    run_last_q <= run_last_d;
    img_last_q <= img_last_d;
    out_w_q    <= out_w_d;
    out_h_q    <= out_h_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = pix_q;
  assign status_o       = status_q;
  assign run_last_o     = run_last_q;
  assign image_last_o   = img_last_q;
  assign image_width_o  = out_w_q;
  assign image_height_o = out_h_q;

endmodule

FILE: rtl/pcx_ctrl.sv
// Controller of the PCX decoder: file phase and run emission sequencing.
// Depends on pcx_pkg; commands pcx_dpath through pcx_cmd_t.
module pcx_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_sof_i,
  input  pcx_pkg::pcx_sts_t  sts_i,
  output logic               in_ready_o,
  output pcx_pkg::pcx_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEADER = 3'd1;
  localparam logic [2:0] S_DATA   = 3'd2;
  localparam logic [2:0] S_DONE   = 3'd3;
  localparam logic [2:0] S_RUN    = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q != S_RUN) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    if (accept && in_sof_i) begin
      cmd_o.clear = 1'b1;
      state_d     = S_HEADER;
    end else if (accept) begin
      case (state_q)
        S_HEADER: begin
          if (sts_i.hdr_check && sts_i.fmt_bad) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_sel  = pcx_pkg::SEL_FMT;
            cmd_o.run_last = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.hdr_step = 1'b1;
            if (sts_i.hdr_last) begin
              cmd_o.load_left = 1'b1;
              state_d         = S_DATA;
            end
          end
        end
        S_DATA: begin
          if (sts_i.run_pending) begin
            cmd_o.take_run = 1'b1;
            if (!sts_i.run_zero) begin
              cmd_o.load_out = 1'b1;
              cmd_o.out_sel  = pcx_pkg::SEL_BYTE;
              cmd_o.dec_run  = 1'b1;
              cmd_o.run_last = sts_i.run_one;
              if (sts_i.run_one) state_d = sts_i.left_one ? S_DONE : S_DATA;
              else               state_d = S_RUN;
            end
          end else if (!sts_i.is_mark) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_sel  = pcx_pkg::SEL_BYTE;
            cmd_o.run_last = 1'b1;
            if (sts_i.left_one) state_d = S_DONE;
          end else begin
            cmd_o.set_run = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_RUN && sts_i.out_free) begin
      cmd_o.load_out = 1'b1;
      if (sts_i.left_zero) begin
        cmd_o.out_sel  = pcx_pkg::SEL_CORRUPT;
        cmd_o.run_last = 1'b1;
        state_d        = S_DONE;
      end else begin
        cmd_o.out_sel  = pcx_pkg::SEL_RUN;
        cmd_o.dec_run  = 1'b1;
        cmd_o.run_last = sts_i.run_one;
        if (sts_i.run_one) state_d = sts_i.left_one ? S_DONE : S_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: tb/pcx_rle_checker.sv
// Checker for the PCX RLE decoder: watches the byte and result channels, predicts
// the result stream and compares it field by field.
// Depends on pcx_pkg and pcx_if.
module pcx_rle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcx_byte_if         byte_i,
  pcx_pix_if          pix_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum logic [1:0] {DEC_IDLE, DEC_HEADER, DEC_DATA, DEC_DONE} dec_phase_e;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [1:0]  status;
    logic        run_last;
    logic        image_last;
    logic [16:0] width;
    logic [16:0] height;
  } pix_result_t;

  pix_result_t pixels_due_q[$];

  dec_phase_e                   phase_q = DEC_IDLE;
  logic [pcx_pkg::HdrIdxW-1:0]  hdr_idx = '0;
  logic [15:0]                  width_q = '0;
  logic [15:0]                  height_q = '0;
  logic                         fmt_ok = 1'b1;
  logic [32:0]                  left_q = '0;
  logic [5:0]                   run_cnt = '0;
  logic                         run_armed = 1'b0;

  function automatic string fmt_result(input pix_result_t r);
    return $sformatf("pix %0d sts %0d run_last %0b img_last %0b w %0d h %0d",
                     r.pixel, r.status, r.run_last, r.image_last, r.width, r.height);
  endfunction

  task automatic clear_file();
    hdr_idx   = '0;
    width_q   = '0;
    height_q  = '0;
    fmt_ok    = 1'b1;
    left_q    = '0;
    run_cnt   = '0;
    run_armed = 1'b0;
  endtask

  task automatic push_result(input logic [7:0] pix, input logic [1:0] sts,
                             input logic img_last);
    pix_result_t res;
    res = {pix, sts, 1'b0, img_last, 17'(width_q) + 17'd1, 17'(height_q) + 17'd1};
    pixels_due_q.push_back(res);
  endtask

  task automatic emit_pixel(input logic [7:0] value);
    left_q = left_q - 33'd1;
    push_result(value, pcx_pkg::STS_PIXEL, left_q == '0);
    if (left_q == '0) phase_q = DEC_DONE;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    int unsigned first;
    logic [5:0]  cnt;
    pix_result_t tail;
    first = pixels_due_q.size();
    if (sof) begin
      clear_file();
      phase_q = DEC_HEADER;
    end
    case (phase_q)
      DEC_HEADER: begin
        if (hdr_idx == pcx_pkg::IDX_ENCODING && b != pcx_pkg::ENC_RLE) fmt_ok = 1'b0;
        if (hdr_idx == pcx_pkg::IDX_BPP && b != pcx_pkg::BPP_8) fmt_ok = 1'b0;
        if (hdr_idx == pcx_pkg::IDX_W_LO) width_q[7:0] = b;
        if (hdr_idx == pcx_pkg::IDX_W_HI) width_q[15:8] = b;
        if (hdr_idx == pcx_pkg::IDX_H_LO) height_q[7:0] = b;
        if (hdr_idx == pcx_pkg::IDX_H_HI) height_q[15:8] = b;
        if (hdr_idx == pcx_pkg::IDX_PLANES && (b != pcx_pkg::PLANES_1 || !fmt_ok)) begin
          push_result(8'd0, pcx_pkg::STS_BAD_FMT, 1'b0);
          phase_q = DEC_DONE;
        end else if (hdr_idx == pcx_pkg::IDX_LAST) begin
          left_q    = (33'(width_q) + 33'd1) * (33'(height_q) + 33'd1);
          run_cnt   = '0;
          run_armed = 1'b0;
          phase_q   = DEC_DATA;
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      DEC_DATA: begin
        if (run_armed) begin
          cnt       = run_cnt;
          run_armed = 1'b0;
          run_cnt   = '0;
          while (cnt != '0 && left_q != '0) begin
            emit_pixel(b);
            cnt = cnt - 6'd1;
          end
          if (cnt != '0) begin
            push_result(8'd0, pcx_pkg::STS_CORRUPT, 1'b0);
            phase_q = DEC_DONE;
          end
        end else if (b < pcx_pkg::RleMark) begin
          emit_pixel(b);
        end else begin
          run_cnt   = 6'(b - pcx_pkg::RleMark);
          run_armed = 1'b1;
        end
      end
      default: ;
    endcase
    if (pixels_due_q.size() > first) begin
      tail = pixels_due_q.pop_back();
      tail.run_last = 1'b1;
      pixels_due_q.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_result_t got;
    pix_result_t want;
    if (!rst_ni) begin
      clear_file();
      phase_q = DEC_IDLE;
      pixels_due_q.delete();
    end else begin
      if (byte_i.valid && byte_i.ready) decode_byte(byte_i.file_byte, byte_i.start_of_file);
      if (pix_i.valid && pix_i.ready) begin
        results_o++;
        got = {pix_i.pixel_value, pix_i.status, pix_i.run_last, pix_i.image_last,
               pix_i.image_width, pix_i.image_height};
        if (pixels_due_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: unexpected result %s", $realtime, fmt_result(got));
        end else begin
          want = pixels_due_q.pop_front();
          if (got.pixel !== want.pixel || got.status !== want.status ||
              got.run_last !== want.run_last || got.image_last !== want.image_last ||
              got.width !== want.width || got.height !== want.height) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT)
              $display("%0t: mismatch, expected %s, got %s",
                       $realtime, fmt_result(want), fmt_result(got));
          end
        end
      end
    end
    pending_o = pixels_due_q.size();
  end

endmodule

FILE: tb/tb_pcx_rle_decoder.sv
// Top of the PCX RLE decoder testbench: clock, reset, byte stimulus, result
// back-pressure, watchdog and verdict.
// Depends on pcx_pkg, pcx_if, pcx_rle_decoder and pcx_rle_checker.
module tb_pcx_rle_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned DATA_ITEMS     = 200;
  localparam int unsigned HEADER_BYTES   = 128;

  typedef enum logic [1:0] {TAIL_CLEAN, TAIL_OVERFLOW, TAIL_CUT} tail_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned idle_cycles;
  int unsigned data_items;
  int unsigned hold_req;
  bit          no_idle;

  pcx_byte_if byte_if ();
  pcx_pix_if  pix_if ();

  pcx_rle_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .pix_o  (pix_if)
  );

  pcx_rle_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_if),
    .pix_i        (pix_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned gap;
    pix_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req != 0) begin
        pix_if.ready = 1'b0;
        repeat (hold_req) @(negedge clk_i);
        hold_req = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        pix_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pix_if.ready = 1'b1;
      @(posedge clk_i);
      while (!pix_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic sof);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid         = 1'b1;
    byte_if.file_byte     = value;
    byte_if.start_of_file = sof;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_data(input logic [7:0] value);
    send_byte(value, 1'b0);
    data_items++;
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_header(input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] enc, input logic [7:0] bpp,
                             input logic [7:0] planes, input int unsigned stop_at);
    logic [7:0]                  value;
    logic [pcx_pkg::HdrIdxW-1:0] idx;
    for (int i = 0; i < stop_at; i++) begin
      idx   = pcx_pkg::HdrIdxW'(i);
      value = 8'($urandom_range(0, 255));
      case (idx)
        pcx_pkg::IDX_ENCODING: value = enc;
        pcx_pkg::IDX_BPP:      value = bpp;
        pcx_pkg::IDX_W_LO:     value = w[7:0];
        pcx_pkg::IDX_W_HI:     value = w[15:8];
        pcx_pkg::IDX_H_LO:     value = h[7:0];
        pcx_pkg::IDX_H_HI:     value = h[15:8];
        pcx_pkg::IDX_PLANES:   value = planes;
        default: ;
      endcase
      send_byte(value, i == 0);
    end
  endtask

  // Well-formed RLE stream of npix pixels, optionally ending in an overflow or cut short.
  task automatic send_image_data(input int unsigned npix, input tail_e tail);
    int unsigned left;
    int unsigned cnt;
    left = npix;
    while (left != 0) begin
      if (tail == TAIL_CUT && $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 1) send_data(8'(pcx_pkg::RleMark + $urandom_range(0, 63)));
        return;
      end
      if (tail == TAIL_OVERFLOW && left < 63 && $urandom_range(0, 2) == 0) begin
        cnt = $urandom_range(left + 1, 63);
        send_data(8'(pcx_pkg::RleMark + cnt));
        send_data(8'($urandom_range(0, 255)));
        return;
      end
      if ($urandom_range(0, 2) == 0) begin
        send_data(8'($urandom_range(0, 191)));
        left--;
      end else begin
        cnt = $urandom_range(0, left < 63 ? left : 63);
        send_data(8'(pcx_pkg::RleMark + cnt));
        send_data(8'($urandom_range(0, 255)));
        left -= cnt;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  enc_v;
    logic [7:0]  bpp_v;
    logic [7:0]  planes_v;
    int unsigned r;
    tail_e       tail;

    rst_ni                = 1'b0;
    byte_if.valid         = 1'b0;
    byte_if.file_byte     = 8'd0;
    byte_if.start_of_file = 1'b0;
    no_idle               = 1'b0;
    hold_req              = 0;
    idle_cycles           = 0;
    data_items            = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drop bytes before any file start
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // 4x2: literals at both ends, empty run, runs, run of value 192, trailing bytes
    send_header(16'd3, 16'd1, pcx_pkg::ENC_RLE, pcx_pkg::BPP_8, pcx_pkg::PLANES_1,
                HEADER_BYTES);
    send_byte(8'd0, 1'b0);
    send_byte(8'd191, 1'b0);
    send_byte(pcx_pkg::RleMark, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'(pcx_pkg::RleMark + 3), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'(pcx_pkg::RleMark + 2), 1'b0);
    send_byte(pcx_pkg::RleMark, 1'b0);
    send_byte(8'h2A, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hC5, 1'b0);

    // 8x8 with the longest run while the result side holds off
    hold_req = HOLD_CYCLES;
    send_header(16'd7, 16'd7, pcx_pkg::ENC_RLE, pcx_pkg::BPP_8, pcx_pkg::PLANES_1,
                HEADER_BYTES);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h07, 1'b0);
    wait_drained();

    // run overflowing a 2x2 image, then ignored bytes
    send_header(16'd1, 16'd1, pcx_pkg::ENC_RLE, pcx_pkg::BPP_8, pcx_pkg::PLANES_1,
                HEADER_BYTES);
    send_byte(8'h10, 1'b0);
    send_byte(8'(pcx_pkg::RleMark + 5), 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h01, 1'b0);

    // unsupported formats
    send_header(16'd3, 16'd3, 8'd0, pcx_pkg::BPP_8, pcx_pkg::PLANES_1, HEADER_BYTES);
    send_byte(8'h05, 1'b0);
    send_header(16'd3, 16'd3, pcx_pkg::ENC_RLE, 8'd4, pcx_pkg::PLANES_1, HEADER_BYTES);
    send_header(16'd3, 16'd3, pcx_pkg::ENC_RLE, pcx_pkg::BPP_8, 8'd3, HEADER_BYTES);

    // restart mid-header, then a 1x1 image
    send_header(16'd5, 16'd5, pcx_pkg::ENC_RLE, pcx_pkg::BPP_8, pcx_pkg::PLANES_1, 40);
    send_header(16'd0, 16'd0, pcx_pkg::ENC_RLE, pcx_pkg::BPP_8, pcx_pkg::PLANES_1,
                HEADER_BYTES);
    send_byte(8'd191, 1'b0);

    // largest image, abandoned with a run pending
    send_header(16'hFFFF, 16'hFFFF, pcx_pkg::ENC_RLE, pcx_pkg::BPP_8, pcx_pkg::PLANES_1,
                HEADER_BYTES);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC4, 1'b0);

    data_items = 0;
    while (data_items < DATA_ITEMS) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      w        = 16'($urandom_range(0, 7));
      h        = 16'($urandom_range(0, 7));
      enc_v    = pcx_pkg::ENC_RLE;
      bpp_v    = pcx_pkg::BPP_8;
      planes_v = pcx_pkg::PLANES_1;
      r        = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 2))
          0:       enc_v    = 8'(pcx_pkg::ENC_RLE + $urandom_range(1, 255));
          1:       bpp_v    = 8'(pcx_pkg::BPP_8 + $urandom_range(1, 255));
          default: planes_v = 8'(pcx_pkg::PLANES_1 + $urandom_range(1, 255));
        endcase
        send_header(w, h, enc_v, bpp_v, planes_v, HEADER_BYTES);
      end else if (r == 1) begin
        send_header(w, h, enc_v, bpp_v, planes_v, $urandom_range(1, HEADER_BYTES - 1));
      end else begin
        case ($urandom_range(0, 5))
          0:       tail = TAIL_OVERFLOW;
          1:       tail = TAIL_CUT;
          default: tail = TAIL_CLEAN;
        endcase
        send_header(w, h, enc_v, bpp_v, planes_v, HEADER_BYTES);
        send_image_data((int'(w) + 1) * (int'(h) + 1), tail);
      end
      if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 3));
    end

    byte_if.valid = 1'b0;
    no_idle       = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
